// ===== rtl/hsv2rgb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared constants: default parameter values, hue sector codes and the
// number of quotient bits resolved per stage of the constant divider.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int HUE_FRAC_BITS_DEF = 4;

    // Whole degrees need nine bits to reach a full turn of 360.
    localparam int HUE_INT_BITS   = 9;
    localparam int DEG_PER_SECTOR = 60;
    localparam int DEG_FULL_TURN  = 360;

    localparam int SEC_W = 3;

    localparam logic [SEC_W-1:0] SEC_R_TO_Y = 3'd0;
    localparam logic [SEC_W-1:0] SEC_Y_TO_G = 3'd1;
    localparam logic [SEC_W-1:0] SEC_G_TO_C = 3'd2;
    localparam logic [SEC_W-1:0] SEC_C_TO_B = 3'd3;
    localparam logic [SEC_W-1:0] SEC_B_TO_M = 3'd4;
    localparam logic [SEC_W-1:0] SEC_M_TO_R = 3'd5;

    // Quotient bits resolved in each register stage of the divider.
    localparam int DIV_STEPS_PER_STAGE = 2;

endpackage
`default_nettype wire

// ===== rtl/hsv2rgb_cdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB constant divider
// Three-lane pipelined restoring division by constant divisors. Lane a
// divides by DEN_A, lanes b and c by DEN_B. Each stage resolves a fixed
// number of quotient bits; a sideband vector and a valid bit travel along.
// ----------------------------------------------------------------------------
module hsv2rgb_cdiv #(
    parameter int              NUM_W  = 34,
    parameter int              Q_W    = 8,
    parameter longint unsigned DEN_A  = 255,
    parameter longint unsigned DEN_B  = 244800,
    parameter int              SIDE_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [NUM_W-1:0]  i_num_a,
    input  wire logic [NUM_W-1:0]  i_num_b,
    input  wire logic [NUM_W-1:0]  i_num_c,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_vld,
    output logic [Q_W-1:0]         o_quo_a,
    output logic [Q_W-1:0]         o_quo_b,
    output logic [Q_W-1:0]         o_quo_c,
    output logic [SIDE_W-1:0]      o_side
);
    import hsv2rgb_pkg::*;

    localparam int N_STG = (Q_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam logic [NUM_W-1:0] DEN_A_W = NUM_W'(DEN_A);
    localparam logic [NUM_W-1:0] DEN_B_W = NUM_W'(DEN_B);

    logic [NUM_W-1:0]  src_rem [0:N_STG-1][0:2];
    logic [Q_W-1:0]    src_quo [0:N_STG-1][0:2];
    logic [SIDE_W-1:0] src_side [0:N_STG-1];
    logic              src_vld [0:N_STG-1];

    logic [NUM_W-1:0]  n_rem [0:N_STG-1][0:2];
    logic [Q_W-1:0]    n_quo [0:N_STG-1][0:2];

    logic [NUM_W-1:0]  r_rem [0:N_STG-1][0:2];
    logic [Q_W-1:0]    r_quo [0:N_STG-1][0:2];
    logic [SIDE_W-1:0] r_side [0:N_STG-1];
    logic              r_vld [0:N_STG-1];

    genvar k;
    generate
        for (k = 0; k < N_STG; k++) begin : g_stg
            if (k == 0) begin : g_first
                assign src_rem[k][0] = i_num_a;
                assign src_rem[k][1] = i_num_b;
                assign src_rem[k][2] = i_num_c;
                assign src_quo[k][0] = '0;
                assign src_quo[k][1] = '0;
                assign src_quo[k][2] = '0;
                assign src_side[k]   = i_side;
                assign src_vld[k]    = i_vld;
            end else begin : g_next
                assign src_rem[k][0] = r_rem[k-1][0];
                assign src_rem[k][1] = r_rem[k-1][1];
                assign src_rem[k][2] = r_rem[k-1][2];
                assign src_quo[k][0] = r_quo[k-1][0];
                assign src_quo[k][1] = r_quo[k-1][1];
                assign src_quo[k][2] = r_quo[k-1][2];
                assign src_side[k]   = r_side[k-1];
                assign src_vld[k]    = r_vld[k-1];
            end

            always_comb begin
                logic [NUM_W-1:0] rem;
                logic [NUM_W-1:0] den;
                logic [Q_W-1:0]   quo;
                int               idx;
                for (int l = 0; l < 3; l++) begin
                    rem = src_rem[k][l];
                    quo = src_quo[k][l];
                    den = (l == 0) ? DEN_A_W : DEN_B_W;
                    for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                        idx = Q_W - 1 - (k * DIV_STEPS_PER_STAGE + j);
                        if (idx >= 0) begin
                            if (rem >= (den << idx)) begin
                                rem      = rem - (den << idx);
                                quo[idx] = 1'b1;
                            end
                        end
                    end
                    n_rem[k][l] = rem;
                    n_quo[k][l] = quo;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= src_vld[k];
                end
                r_side[k] <= src_side[k];
                for (int l = 0; l < 3; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_quo[k][l] <= n_quo[k][l];
                end
            end
        end
    endgenerate

    assign o_vld   = r_vld[N_STG-1];
    assign o_quo_a = r_quo[N_STG-1][0];
    assign o_quo_b = r_quo[N_STG-1][1];
    assign o_quo_c = r_quo[N_STG-1][2];
    assign o_side  = r_side[N_STG-1];

endmodule
`default_nettype wire

// ===== rtl/hsv_to_rgb_converter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Fixed-point HSV to RGB conversion. Hue is in 1/2^HUE_FRAC_BITS degree
// units, channels are fractions of 2^CHANNEL_BITS - 1, and each level is
// rounded to nearest with ties up.
//
//   Channel | Ports                                   | Beat marker
//   --------+-----------------------------------------+--------------------
//   In      | i_hue, i_saturation, i_brightness       | start high, busy low
//   Out     | o_red, o_green, o_blue                  | o_valid, one cycle
//
// A new beat is taken every cycle; busy is always low. Each beat passes
// through three stages of sector split and products, the divider pipeline
// that resolves two quotient bits per stage, and the output register. Reset
// clears only the valid bits. The receiver cannot stall, so nothing is ever
// held.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
    parameter int CHANNEL_BITS  = hsv2rgb_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        start,
    output logic                                             busy,
    input  wire logic [hsv2rgb_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] i_hue,
    input  wire logic [CHANNEL_BITS-1:0]                     i_saturation,
    input  wire logic [CHANNEL_BITS-1:0]                     i_brightness,
    output logic                                             o_valid,
    output logic [CHANNEL_BITS-1:0]                          o_red,
    output logic [CHANNEL_BITS-1:0]                          o_green,
    output logic [CHANNEL_BITS-1:0]                          o_blue
);
    import hsv2rgb_pkg::*;

    localparam int              CB        = CHANNEL_BITS;
    localparam int              HUE_W     = HUE_INT_BITS + HUE_FRAC_BITS;
    localparam int              SEC_UNITS = DEG_PER_SECTOR << HUE_FRAC_BITS;
    localparam int              FULL_TURN = DEG_FULL_TURN << HUE_FRAC_BITS;
    localparam int              F_W       = $clog2(SEC_UNITS + 1);
    localparam int              SF_W      = CB + F_W;
    localparam longint unsigned CH_MAX    = (longint'(1) << CB) - 1;
    localparam longint unsigned BIG       = CH_MAX * longint'(SEC_UNITS);
    localparam int              BIG_W     = $clog2(BIG + 1);
    localparam int              NUM_W     = CB + BIG_W;
    localparam int              SIDE_W    = 1 + SEC_W + CB;

    logic accept;

    // Stage 1: hue of a full turn or more forced to zero, sector and fraction.
    logic [HUE_W-1:0] hue_w;
    logic [SEC_W-1:0] n1_sec;
    logic [HUE_W-1:0] sec_base;
    logic [F_W-1:0]   n1_f;

    logic             r1_vld;
    logic [SEC_W-1:0] r1_sec;
    logic [F_W-1:0]   r1_f;
    logic [CB-1:0]    r1_s;
    logic [CB-1:0]    r1_v;
    logic             r1_grey;

    // Stage 2: first products.
    logic             r2_vld;
    logic [SEC_W-1:0] r2_sec;
    logic [CB-1:0]    r2_v;
    logic             r2_grey;
    logic [SF_W-1:0]  r2_sf;
    logic [SF_W-1:0]  r2_sdf;
    logic [NUM_W-1:0] r2_nump;

    // Stage 3: rounded numerators.
    logic             r3_vld;
    logic [SIDE_W-1:0] r3_side;
    logic [NUM_W-1:0] r3_nump;
    logic [NUM_W-1:0] r3_numq;
    logic [NUM_W-1:0] r3_numt;

    // Divider outputs.
    logic              d_vld;
    logic [CB-1:0]     d_p;
    logic [CB-1:0]     d_q;
    logic [CB-1:0]     d_t;
    logic [SIDE_W-1:0] d_side;
    logic              d_grey;
    logic [SEC_W-1:0]  d_sec;
    logic [CB-1:0]     d_v;

    logic [CB-1:0] n_red;
    logic [CB-1:0] n_green;
    logic [CB-1:0] n_blue;
    logic          r_valid;
    logic [CB-1:0] r_red;
    logic [CB-1:0] r_green;
    logic [CB-1:0] r_blue;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        hue_w = (i_hue >= HUE_W'(FULL_TURN)) ? '0 : i_hue;
        if (hue_w >= HUE_W'(5 * SEC_UNITS)) begin
            n1_sec   = SEC_M_TO_R;
            sec_base = HUE_W'(5 * SEC_UNITS);
        end else if (hue_w >= HUE_W'(4 * SEC_UNITS)) begin
            n1_sec   = SEC_B_TO_M;
            sec_base = HUE_W'(4 * SEC_UNITS);
        end else if (hue_w >= HUE_W'(3 * SEC_UNITS)) begin
            n1_sec   = SEC_C_TO_B;
            sec_base = HUE_W'(3 * SEC_UNITS);
        end else if (hue_w >= HUE_W'(2 * SEC_UNITS)) begin
            n1_sec   = SEC_G_TO_C;
            sec_base = HUE_W'(2 * SEC_UNITS);
        end else if (hue_w >= HUE_W'(SEC_UNITS)) begin
            n1_sec   = SEC_Y_TO_G;
            sec_base = HUE_W'(SEC_UNITS);
        end else begin
            n1_sec   = SEC_R_TO_Y;
            sec_base = '0;
        end
        n1_f = F_W'(hue_w - sec_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end

        r1_sec  <= n1_sec;
        r1_f    <= n1_f;
        r1_s    <= i_saturation;
        r1_v    <= i_brightness;
        r1_grey <= (i_saturation == '0);

        r2_sec  <= r1_sec;
        r2_v    <= r1_v;
        r2_grey <= r1_grey;
        r2_sf   <= SF_W'(r1_s) * SF_W'(r1_f);
        r2_sdf  <= SF_W'(r1_s) * SF_W'(F_W'(SEC_UNITS) - r1_f);
        r2_nump <= NUM_W'(r1_v) * NUM_W'(CB'(CH_MAX) - r1_s) + NUM_W'(CH_MAX / 2);

        r3_side <= {r2_grey, r2_sec, r2_v};
        r3_nump <= r2_nump;
        r3_numq <= NUM_W'(r2_v) * (NUM_W'(BIG) - NUM_W'(r2_sf)) + NUM_W'(BIG / 2);
        r3_numt <= NUM_W'(r2_v) * (NUM_W'(BIG) - NUM_W'(r2_sdf)) + NUM_W'(BIG / 2);
    end

    hsv2rgb_cdiv #(
        .NUM_W  (NUM_W),
        .Q_W    (CB),
        .DEN_A  (CH_MAX),
        .DEN_B  (BIG),
        .SIDE_W (SIDE_W)
    ) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_num_a (r3_nump),
        .i_num_b (r3_numq),
        .i_num_c (r3_numt),
        .i_side  (r3_side),
        .o_vld   (d_vld),
        .o_quo_a (d_p),
        .o_quo_b (d_q),
        .o_quo_c (d_t),
        .o_side  (d_side)
    );

    assign {d_grey, d_sec, d_v} = d_side;

    always_comb begin
        if (d_grey) begin
            n_red   = d_v;
            n_green = d_v;
            n_blue  = d_v;
        end else begin
            case (d_sec)
                SEC_R_TO_Y: begin
                    n_red = d_v; n_green = d_t; n_blue = d_p;
                end
                SEC_Y_TO_G: begin
                    n_red = d_q; n_green = d_v; n_blue = d_p;
                end
                SEC_G_TO_C: begin
                    n_red = d_p; n_green = d_v; n_blue = d_t;
                end
                SEC_C_TO_B: begin
                    n_red = d_p; n_green = d_q; n_blue = d_v;
                end
                SEC_B_TO_M: begin
                    n_red = d_t; n_green = d_p; n_blue = d_v;
                end
                default: begin
                    n_red = d_v; n_green = d_p; n_blue = d_q;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_vld;
        end
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule
`default_nettype wire
